// File: rtl/skt_pkg.sv
// Shared types and constants of the sorted key tracker table.
package skt_pkg;

   localparam int DEPTH = 16;
   localparam int KEY_W = 22;
   localparam int TAG_W = 32;
   localparam int CAP_W = 5;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BADARG   = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic {
      REQ_TRACK   = 1'b0,
      REQ_UNTRACK = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } entry_type;

   // Broadcast from the control to every cell
   typedef struct packed {
      logic             ins;
      logic             rem;
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } cell_cmd_type;

   // Compare results of one cell against the broadcast key
   typedef struct packed {
      logic gt;
      logic eq;
      logic first;
   } cell_flags_type;

endpackage

// File: rtl/skt_channels.sv
// Channel interfaces of the sorted key tracker table: request, response, register write.
interface skt_req_if;
   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic [skt_pkg::KEY_W-1:0] proc_key;
   logic [skt_pkg::TAG_W-1:0] tag_in;

   modport source (output valid, req_type, proc_key, tag_in, input ready);
   modport sink   (input valid, req_type, proc_key, tag_in, output ready);
endinterface

interface skt_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                status;
   logic [skt_pkg::TAG_W-1:0] tag_out;

   modport source (output valid, status, tag_out, input ready);
   modport sink   (input valid, status, tag_out, output ready);
endinterface

interface skt_csr_if;
   logic                      valid;
   logic                      ready;
   logic [skt_pkg::CAP_W-1:0] capacity_limit;

   modport source (output valid, capacity_limit, input ready);
   modport sink   (input valid, capacity_limit, output ready);
endinterface

// File: rtl/skt_cell.sv
// One table cell: holds an entry, compares it with the broadcast key, shifts with neighbours.
module skt_cell (
   input  logic                    clock,
   input  skt_pkg::cell_cmd_type   cmd,
   input  logic                    occupied,
   input  skt_pkg::entry_type      left_entry,
   input  logic                    left_gt,
   input  logic                    left_eq,
   input  skt_pkg::entry_type      right_entry,
   output skt_pkg::entry_type      entry,
   output skt_pkg::cell_flags_type flags
);

   skt_pkg::entry_type entry_ff;
   skt_pkg::entry_type entry_in;
   logic               ge;

   assign entry = entry_ff;

   // An empty cell counts as greater, so the insert point is the first greater cell
   assign flags.gt    = !occupied || (entry_ff.key > cmd.key);
   assign flags.eq    = occupied && (entry_ff.key == cmd.key);
   assign flags.first = flags.eq && !left_eq;
   assign ge          = occupied && !(entry_ff.key < cmd.key);

   always_comb begin
      entry_in = entry_ff;
      priority if (cmd.ins && left_gt) begin
         entry_in = left_entry;
      end else if (cmd.ins && flags.gt) begin
         entry_in.key = cmd.key;
         entry_in.tag = cmd.tag;
      end else if (cmd.rem && ge) begin
         entry_in = right_entry;
      end else begin
         // Hold the entry
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: rtl/sorted_key_tracker_table_unit.sv
// Top level of the sorted key tracker table: control, response register and the cell row.
//
// Keeps up to DEPTH (key, tag) entries in ascending key order, one entry per cell.
// req_ch carries track (insert) and untrack (remove) items; rsp_ch returns one item
// per request with a status and, for a successful untrack, the removed tag.
// csr_ch (always ready) writes capacity_limit; the user must write it only while idle;
// the block does not check. Latency: the response is valid the cycle after acceptance.
// Throughput: one request per cycle while rsp_ch.ready is high. Every cell compares its
// stored key with the broadcast key and shifts towards or away from its neighbour in the
// same cycle, so the figure is set by one key compare per cell plus the match reduction.
// Stall: the response register holds while rsp_ch.ready is low; a new request
// is taken in the same cycle the waiting response leaves, otherwise held off.
// Reset: empties the table (count zero), sets capacity_limit to 16 and drops
// any pending response. Cell contents are not cleared; only occupied cells count.
module sorted_key_tracker_table_unit (
   input logic       clock,
   input logic       reset,
   skt_req_if.sink   req_ch,
   skt_rsp_if.source rsp_ch,
   skt_csr_if.sink   csr_ch
);

   logic [skt_pkg::CAP_W-1:0] cap_ff;
   logic [skt_pkg::CAP_W-1:0] cap_in;
   logic [skt_pkg::CNT_W-1:0] count_ff;
   logic [skt_pkg::CNT_W-1:0] count_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   skt_pkg::status_type       rsp_status_ff;
   skt_pkg::status_type       rsp_status_in;
   logic [skt_pkg::TAG_W-1:0] rsp_tag_ff;
   logic [skt_pkg::TAG_W-1:0] rsp_tag_in;

   logic                      req_acc;
   logic                      key_zero;
   logic                      is_untrack;
   logic                      full;
   logic                      found;
   logic [skt_pkg::CMP_W-1:0] cap_eff;
   logic [skt_pkg::TAG_W-1:0] tag_sel;
   logic [skt_pkg::DEPTH-1:0] first_vec;

   skt_pkg::cell_cmd_type     cmd;
   skt_pkg::entry_type        entries [skt_pkg::DEPTH];
   skt_pkg::cell_flags_type   flags   [skt_pkg::DEPTH];

   // Handshakes: take a request when the response slot is free or emptying
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.status  = rsp_status_ff;
   assign rsp_ch.tag_out = rsp_tag_ff;

   assign key_zero   = (req_ch.proc_key == '0);
   assign is_untrack = (req_ch.req_type == skt_pkg::REQ_UNTRACK);

   // Saturate the capacity at the table depth
   assign cap_eff = (skt_pkg::CMP_W'(cap_ff) > skt_pkg::CMP_W'(skt_pkg::DEPTH))
                  ? skt_pkg::CMP_W'(skt_pkg::DEPTH) : skt_pkg::CMP_W'(cap_ff);
   assign full    = (skt_pkg::CMP_W'(count_ff) >= cap_eff);

   // Broadcast the command; the cells decide locally whether to shift
   assign cmd.key = req_ch.proc_key;
   assign cmd.tag = req_ch.tag_in;
   assign cmd.ins = req_acc && !key_zero && !is_untrack && !full;
   assign cmd.rem = req_acc && !key_zero && is_untrack && found;

   // Row of cells: insert shifts right from the insert point, remove shifts left
   for (genvar g = 0; g < skt_pkg::DEPTH; g++) begin : g_cell
      skt_pkg::entry_type left_entry;
      skt_pkg::entry_type right_entry;
      logic               left_gt;
      logic               left_eq;
      logic               occupied;

      assign occupied = (count_ff > skt_pkg::CNT_W'(g));

      if (g == 0) begin : g_head
         assign left_entry = entries[g];
         assign left_gt    = 1'b0;
         assign left_eq    = 1'b0;
      end else begin : g_body
         assign left_entry = entries[g-1];
         assign left_gt    = flags[g-1].gt;
         assign left_eq    = flags[g-1].eq;
      end

      if (g == skt_pkg::DEPTH - 1) begin : g_tail
         assign right_entry = entries[g];
      end else begin : g_mid
         assign right_entry = entries[g+1];
      end

      skt_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (occupied),
         .left_entry  (left_entry),
         .left_gt     (left_gt),
         .left_eq     (left_eq),
         .right_entry (right_entry),
         .entry       (entries[g]),
         .flags       (flags[g])
      );

      assign first_vec[g] = flags[g].first;
   end

   // At most one cell is the first match, so an OR selects its tag
   always_comb begin
      tag_sel = '0;
      for (int i = 0; i < skt_pkg::DEPTH; i++) begin
         tag_sel = tag_sel | (first_vec[i] ? entries[i].tag : '0);
      end
   end

   assign found = |first_vec;

   always_comb begin
      cap_in        = cap_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;

      if (csr_ch.valid && csr_ch.ready) begin
         cap_in = csr_ch.capacity_limit;
      end

      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (req_acc) begin
         rsp_valid_in = 1'b1;
         rsp_tag_in   = '0;
         priority if (key_zero) begin
            rsp_status_in = skt_pkg::ST_BADARG;
         end else if (!is_untrack) begin
            rsp_status_in = full ? skt_pkg::ST_FULL : skt_pkg::ST_OK;
         end else begin
            rsp_status_in = found ? skt_pkg::ST_OK : skt_pkg::ST_NOTFOUND;
            rsp_tag_in    = found ? tag_sel : '0;
         end
      end

      // Advance the fill count with the cell shifts
      if (cmd.ins) begin
         count_in = count_ff + skt_pkg::CNT_W'(1);
      end else if (cmd.rem) begin
         count_in = count_ff - skt_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= skt_pkg::CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= skt_pkg::CNT_W'(skt_pkg::DEPTH))
      else $error("fill count beyond table depth");

   a_first_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(first_vec))
      else $error("more than one first-match cell");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      cmd.ins |=> (count_ff == $past(count_ff) + skt_pkg::CNT_W'(1)))
      else $error("insert did not grow the table");

   a_remove_status: assert property (@(posedge clock) disable iff (reset)
      cmd.rem |=> (rsp_valid_ff && rsp_status_ff == skt_pkg::ST_OK))
      else $error("remove did not answer ok");
`endif

endmodule
